// ----- design/sckb_pkg.sv -----
// ============================================================================
// sckb_pkg
// Shared types and constants for the color-keyed 4bpp sprite blitter.
// ============================================================================
`default_nettype none

package sckb_pkg;

    // Fixed field widths
    localparam int WordW      = 32;
    localparam int PixW       = 4;
    localparam int PixPerWord = 8;
    localparam int SelW       = 3;
    localparam int ColW       = 7;
    localparam int RowW       = 10;
    localparam int AddrW      = 17;
    localparam int FrameRowW  = 11;
    localparam int DimW       = 13;   // holds frame dimensions up to 4096

    // Stream and configuration port widths
    localparam int STdataW    = 56;
    localparam int MTdataW    = 24;
    localparam int CfgIdxW    = 4;
    localparam int CfgDataW   = 10;

    // Job queue between the classifier and the write generator
    localparam int FifoDepth  = 4;
    localparam int FifoPtrW   = 2;

    // Default frame geometry
    localparam int FRAME_WIDTH_DEF  = 320;
    localparam int FRAME_HEIGHT_DEF = 240;

    // Configuration register indexes
    typedef enum logic [CfgIdxW-1:0] {
        REG_DEST_X        = 4'd0,
        REG_DEST_Y        = 4'd1,
        REG_REGION_WIDTH  = 4'd2,
        REG_REGION_HEIGHT = 4'd3,
        REG_OFFSET_X      = 4'd4,
        REG_OFFSET_Y      = 4'd5,
        REG_KEY_ENABLE    = 4'd6,
        REG_KEY_COLOR     = 4'd7
    } cfg_reg_t;

    // Reset values of the keying registers
    localparam logic            KEY_ENABLE_RST = 1'b1;
    localparam logic [PixW-1:0] KEY_COLOR_RST  = 4'hd;

    typedef struct packed {
        logic [8:0]      dest_x;
        logic [7:0]      dest_y;
        logic [9:0]      region_width;
        logic [9:0]      region_height;
        logic [9:0]      offset_x;
        logic [9:0]      offset_y;
        logic            key_enable;
        logic [PixW-1:0] key_color;
    } cfg_t;

    // One classified word: pixels, surviving-pixel mask, address of nibble 0
    typedef struct packed {
        logic [WordW-1:0]      word;
        logic [PixPerWord-1:0] mask;
        logic [AddrW-1:0]      base;
    } blit_job_t;

    typedef struct packed {
        logic full;
        logic empty;
    } fifo_stat_t;

endpackage

`default_nettype wire

// ----- design/sckb_front.sv -----
// ============================================================================
// sckb_front
// Configuration registers, item intake and classification: window, key and
// frame clipping per pixel, then the frame address of the word's first pixel.
// ============================================================================
`default_nettype none

module sckb_front #(
    parameter int FRAME_WIDTH  = sckb_pkg::FRAME_WIDTH_DEF,
    parameter int FRAME_HEIGHT = sckb_pkg::FRAME_HEIGHT_DEF
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [sckb_pkg::CfgIdxW-1:0]   cfg_index,
    input  wire logic [sckb_pkg::CfgDataW-1:0]  cfg_data,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    input  wire logic [sckb_pkg::STdataW-1:0]   s_tdata,
    output logic                                job_valid,
    input  wire logic                           job_ready,
    output sckb_pkg::blit_job_t                 job
);
    import sckb_pkg::*;

    localparam logic [DimW-1:0] FrameW = DimW'(FRAME_WIDTH);
    localparam logic [DimW-1:0] FrameH = DimW'(FRAME_HEIGHT);

    cfg_t cfg_reg;

    // Stage A: classified item
    logic                  a_valid_reg;
    logic [WordW-1:0]      a_word_reg;
    logic [PixPerWord-1:0] a_mask_reg;
    logic [FrameRowW-1:0]  a_frow_reg;
    logic [AddrW-1:0]      a_colbase_reg;

    // Stage B: addressed job
    logic                  b_valid_reg;
    blit_job_t             b_job_reg;

    logic                  a_ready;
    logic                  b_ready;

    logic [WordW-1:0]      in_word;
    logic [ColW-1:0]       in_wcol;
    logic [RowW-1:0]       in_srow;

    logic                  row_ok;
    logic [FrameRowW-1:0]  frow;
    logic [PixPerWord-1:0] mask;
    logic [AddrW-1:0]      colbase;
    logic [RowW:0]         row_end;
    logic [RowW:0]         col_end;
    logic [DimW+FrameRowW-1:0] row_prod;

    // Configuration writes, always accepted
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.dest_x        <= '0;
            cfg_reg.dest_y        <= '0;
            cfg_reg.region_width  <= '0;
            cfg_reg.region_height <= '0;
            cfg_reg.offset_x      <= '0;
            cfg_reg.offset_y      <= '0;
            cfg_reg.key_enable    <= KEY_ENABLE_RST;
            cfg_reg.key_color     <= KEY_COLOR_RST;
        end else if (cfg_valid) begin
            case (cfg_reg_t'(cfg_index))
                REG_DEST_X:        cfg_reg.dest_x        <= cfg_data[8:0];
                REG_DEST_Y:        cfg_reg.dest_y        <= cfg_data[7:0];
                REG_REGION_WIDTH:  cfg_reg.region_width  <= cfg_data[9:0];
                REG_REGION_HEIGHT: cfg_reg.region_height <= cfg_data[9:0];
                REG_OFFSET_X:      cfg_reg.offset_x      <= cfg_data[9:0];
                REG_OFFSET_Y:      cfg_reg.offset_y      <= cfg_data[9:0];
                REG_KEY_ENABLE:    cfg_reg.key_enable    <= cfg_data[0];
                REG_KEY_COLOR:     cfg_reg.key_color     <= cfg_data[PixW-1:0];
                default: ;
            endcase
        end
    end

    // Input unpacking
    assign in_word = s_tdata[31:0];
    assign in_wcol = s_tdata[38:32];
    assign in_srow = s_tdata[48:39];

    // Row test and frame row
    assign row_end = {1'b0, cfg_reg.offset_y} + {1'b0, cfg_reg.region_height};
    assign frow    = FrameRowW'(cfg_reg.dest_y) + FrameRowW'(in_srow)
                   - FrameRowW'(cfg_reg.offset_y);
    assign row_ok  = (in_srow >= cfg_reg.offset_y) && ({1'b0, in_srow} < row_end)
                   && (DimW'(frow) < FrameH);

    // Per-pixel tests, independent lanes
    assign col_end = {1'b0, cfg_reg.offset_x} + {1'b0, cfg_reg.region_width};

    always_comb begin
        logic [RowW-1:0]      scol;
        logic [PixW-1:0]      pix;
        logic [FrameRowW-1:0] fcol;
        logic                 in_win;
        logic                 keyed;
        mask = '0;
        for (int k = 0; k < PixPerWord; k++) begin
            scol   = {in_wcol, SelW'(k)};
            pix    = in_word[k*PixW +: PixW];
            in_win = (scol >= cfg_reg.offset_x) && ({1'b0, scol} < col_end);
            keyed  = cfg_reg.key_enable && (pix == cfg_reg.key_color);
            fcol   = FrameRowW'(cfg_reg.dest_x) + FrameRowW'(scol)
                   - FrameRowW'(cfg_reg.offset_x);
            mask[k] = in_win && !keyed && (DimW'(fcol) < FrameW);
        end
    end

    // Frame column of nibble 0, modulo the address width
    assign colbase = AddrW'(cfg_reg.dest_x) + AddrW'({in_wcol, 3'b000})
                   - AddrW'(cfg_reg.offset_x);

    // Handshake through the two stages
    assign b_ready  = !b_valid_reg || job_ready;
    assign a_ready  = !a_valid_reg || b_ready;
    assign s_tready = a_ready;

    // Stage A: items with no surviving pixel are dropped here
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
        end else if (a_ready) begin
            a_valid_reg <= s_tvalid && row_ok && (mask != '0);
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && a_ready) begin
            a_word_reg    <= in_word;
            a_mask_reg    <= mask;
            a_frow_reg    <= frow;
            a_colbase_reg <= colbase;
        end
    end

    // Stage B: row times frame width plus column base
    assign row_prod = a_frow_reg * FrameW;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg <= 1'b0;
        end else if (b_ready) begin
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (a_valid_reg && b_ready) begin
            b_job_reg.word <= a_word_reg;
            b_job_reg.mask <= a_mask_reg;
            b_job_reg.base <= row_prod[AddrW-1:0] + a_colbase_reg;
        end
    end

    assign job_valid = b_valid_reg;
    assign job       = b_job_reg;

endmodule

`default_nettype wire

// ----- design/sckb_fifo.sv -----
// ============================================================================
// sckb_fifo
// Short job queue that decouples the classifier from the write generator.
// ============================================================================
`default_nettype none

module sckb_fifo (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 push,
    input  wire sckb_pkg::blit_job_t  push_data,
    input  wire logic                 pop,
    output sckb_pkg::blit_job_t       pop_data,
    output sckb_pkg::fifo_stat_t      stat
);
    import sckb_pkg::*;

    blit_job_t           mem_reg [FifoDepth];
    logic [FifoPtrW-1:0] wr_ptr_reg;
    logic [FifoPtrW-1:0] rd_ptr_reg;
    logic [FifoPtrW:0]   count_reg;
    logic                do_push;
    logic                do_pop;

    assign stat.full  = (count_reg == (FifoPtrW+1)'(FifoDepth));
    assign stat.empty = (count_reg == '0);

    assign do_push = push && !stat.full;
    assign do_pop  = pop && !stat.empty;

    // Pointers and fill level
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (do_pop)  rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (do_push && !do_pop)      count_reg <= count_reg + 1'b1;
            else if (do_pop && !do_push) count_reg <= count_reg - 1'b1;
        end
    end

    // Entry storage
    always_ff @(posedge aclk) begin
        if (do_push) mem_reg[wr_ptr_reg] <= push_data;
    end

    assign pop_data = mem_reg[rd_ptr_reg];

endmodule

`default_nettype wire

// ----- design/sckb_back.sv -----
// ============================================================================
// sckb_back
// Write generator: walks a job's pixel mask lowest nibble first and emits one
// frame-buffer write per cycle unless stalled, through an output register.
// ============================================================================
`default_nettype none

module sckb_back (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          job_avail,
    input  wire sckb_pkg::blit_job_t           job,
    output logic                               job_pop,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [sckb_pkg::MTdataW-1:0]       m_tdata,
    output logic                               m_tlast,
    output logic                               busy
);
    import sckb_pkg::*;

    // Job being worked on
    logic                  work_valid_reg;
    logic [WordW-1:0]      work_word_reg;
    logic [PixPerWord-1:0] work_mask_reg;
    logic [AddrW-1:0]      work_base_reg;

    // Output register
    logic                  out_valid_reg;
    logic [AddrW-1:0]      out_addr_reg;
    logic [PixW-1:0]       out_pix_reg;
    logic                  out_last_reg;

    logic [PixPerWord-1:0] low_bit;
    logic [PixPerWord-1:0] rest_mask;
    logic [SelW-1:0]       sel;
    logic                  is_last;
    logic                  emit;
    logic                  load;

    // Lowest remaining pixel
    assign low_bit   = work_mask_reg & (~work_mask_reg + 1'b1);
    assign rest_mask = work_mask_reg & ~low_bit;
    assign is_last   = (rest_mask == '0);

    always_comb begin
        sel = '0;
        for (int k = PixPerWord - 1; k >= 0; k--) begin
            if (work_mask_reg[k]) sel = SelW'(k);
        end
    end

    assign emit    = work_valid_reg && (!out_valid_reg || m_tready);
    assign load    = job_avail && (!work_valid_reg || (emit && is_last));
    assign job_pop = load;

    // Work register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            work_valid_reg <= 1'b0;
        end else if (load) begin
            work_valid_reg <= 1'b1;
        end else if (emit && is_last) begin
            work_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            work_word_reg <= job.word;
            work_mask_reg <= job.mask;
            work_base_reg <= job.base;
        end else if (emit) begin
            work_mask_reg <= rest_mask;
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (emit) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            out_addr_reg <= work_base_reg + AddrW'(sel);
            out_pix_reg  <= work_word_reg[sel*PixW +: PixW];
            out_last_reg <= is_last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000, out_pix_reg, out_addr_reg};
    assign m_tlast  = out_last_reg;
    assign busy     = work_valid_reg;

endmodule

`default_nettype wire

// ----- design/sprite_color_key_blitter_core.sv -----
// ============================================================================
// sprite_color_key_blitter_core
// Color-keyed 4bpp sprite blitter: sheet words in, frame-buffer writes out.
// ============================================================================
// Each input item is one sheet word of eight 4-bit pixels; every pixel that
// lies in the source window, is not the key color (when keying is on) and
// lands inside the frame becomes one write item, lowest nibble first, with
// tlast on the word's final write. Words with no surviving pixel produce
// nothing. Items are taken every cycle while the job queue has room; the
// write side emits one write per cycle while m_tready is high, so a word
// with n surviving pixels occupies the output for n writes (up to eight).
// A word passes through classify, address multiply, queue, work register
// and output register. Registers are written through the cfg channel,
// which is always ready; write them only while the block is idle.
`default_nettype none

module sprite_color_key_blitter_core #(
    parameter int FRAME_WIDTH  = sckb_pkg::FRAME_WIDTH_DEF,
    parameter int FRAME_HEIGHT = sckb_pkg::FRAME_HEIGHT_DEF
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    // Configuration writes
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [sckb_pkg::CfgIdxW-1:0]  cfg_index,
    input  wire logic [sckb_pkg::CfgDataW-1:0] cfg_data,
    // Sheet words
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    // [31:0] pixel_word, [38:32] word_column, [48:39] sheet_row, rest zero
    input  wire logic [sckb_pkg::STdataW-1:0]  s_tdata,
    // Frame-buffer writes
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // [16:0] write_address, [20:17] pixel_value, rest zero
    output logic [sckb_pkg::MTdataW-1:0]       m_tdata,
    output logic                               m_tlast
);
    import sckb_pkg::*;

    logic       job_valid;
    blit_job_t  push_job;
    blit_job_t  pop_job;
    logic       job_pop;
    fifo_stat_t fifo_stat;
    logic       back_busy;

    // Classifier
    sckb_front #(
        .FRAME_WIDTH  (FRAME_WIDTH),
        .FRAME_HEIGHT (FRAME_HEIGHT)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .job_valid (job_valid),
        .job_ready (!fifo_stat.full),
        .job       (push_job)
    );

    // Job queue
    sckb_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (job_valid),
        .push_data (push_job),
        .pop       (job_pop),
        .pop_data  (pop_job),
        .stat      (fifo_stat)
    );

    // Write generator
    sckb_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .job_avail (!fifo_stat.empty),
        .job       (pop_job),
        .job_pop   (job_pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .busy      (back_busy)
    );

`ifndef SYNTHESIS
    localparam bit FrameFits = (FRAME_WIDTH * FRAME_HEIGHT) <= (1 << AddrW);
    localparam logic [AddrW:0] FrameSize = (AddrW+1)'(FRAME_WIDTH * FRAME_HEIGHT);

    // A non-final write leaves pixels of its word in the work register
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && !m_tlast) |-> back_busy)
        else $error("non-final write taken with no word in progress");

    // Every write lands inside the frame
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && FrameFits) |-> ({1'b0, m_tdata[AddrW-1:0]} < FrameSize))
        else $error("write address outside the frame");
`endif

endmodule

`default_nettype wire

// ----- dv/testbench.sv -----
// ============================================================================
// testbench
// Self-checking testbench for the color-keyed 4bpp sprite blitter core.
// ============================================================================
// Sheet words go in on the s_ stream. For every word that is accepted, a
// behavioral blitter computes the frame-buffer writes it must cause. Each
// write seen on the m_ stream is checked against the oldest of these.
// Directed words cover the window edges, the frame edges, keying, the
// register masking and writes to unmapped register indexes. Random traffic
// follows, under several window settings, with the sender idling and the
// receiver stalling at random.

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import sckb_pkg::*;

    localparam int FRAME_W      = FRAME_WIDTH_DEF;
    localparam int FRAME_H      = FRAME_HEIGHT_DEF;
    localparam int DRAIN_CYCLES = 24;
    localparam int LIMIT_NS     = 5_000_000;
    localparam int MAX_REPORTS  = 10;
    localparam int NUM_REGS     = 8;

    localparam logic [CfgIdxW-1:0] FIRST_UNMAPPED_REG = 4'd8;
    localparam logic [CfgIdxW-1:0] LAST_REG_INDEX     = 4'd15;

    // One frame-buffer write
    typedef struct packed {
        logic [AddrW-1:0] address;
        logic [PixW-1:0]  pixel;
        logic             last;
    } frame_write_t;

    logic                aclk      = 1'b0;
    logic                aresetn   = 1'b0;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [CfgIdxW-1:0]  cfg_index = '0;
    logic [CfgDataW-1:0] cfg_data  = '0;
    logic                s_tvalid  = 1'b0;
    logic                s_tready;
    logic [STdataW-1:0]  s_tdata   = '0;
    logic                m_tvalid;
    logic                m_tready  = 1'b0;
    logic [MTdataW-1:0]  m_tdata;
    logic                m_tlast;

    // Shadow of the register file and pending writes
    cfg_t                window_cfg;
    logic [CfgDataW-1:0] reg_image [NUM_REGS];
    frame_write_t        expected_writes [$];

    int error_count     = 0;
    int sender_idle_pct = 0;
    int recv_stall_pct  = 0;

    sprite_color_key_blitter_core #(
        .FRAME_WIDTH  (FRAME_W),
        .FRAME_HEIGHT (FRAME_H)
    ) DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    always #5 aclk = ~aclk;

    // Writes one word is expected to cause, lowest nibble first
    function automatic void predict_frame_writes(input logic [WordW-1:0] word,
                                                 input logic [ColW-1:0] col,
                                                 input logic [RowW-1:0] row);
        int unsigned  frame_row;
        int unsigned  sheet_col;
        int unsigned  frame_col;
        logic [3:0]   pix;
        frame_write_t w;
        frame_write_t batch [$];
        if (row < window_cfg.offset_y ||
            int'(row) >= int'(window_cfg.offset_y) + int'(window_cfg.region_height))
            return;
        frame_row = int'(window_cfg.dest_y) + int'(row) - int'(window_cfg.offset_y);
        if (frame_row >= FRAME_H)
            return;
        for (int k = 0; k < PixPerWord; k++) begin
            sheet_col = int'(col) * PixPerWord + k;
            pix = word[4*k +: 4];
            if (sheet_col < window_cfg.offset_x ||
                sheet_col >= int'(window_cfg.offset_x) + int'(window_cfg.region_width))
                continue;
            if (window_cfg.key_enable && pix == window_cfg.key_color)
                continue;
            frame_col = int'(window_cfg.dest_x) + sheet_col - int'(window_cfg.offset_x);
            if (frame_col >= FRAME_W)
                continue;
            w.address = AddrW'(frame_row * FRAME_W + frame_col);
            w.pixel   = pix;
            w.last    = 1'b0;
            batch.push_back(w);
        end
        if (batch.size() > 0) begin
            w = batch.pop_back();
            w.last = 1'b1;
            batch.push_back(w);
        end
        foreach (batch[i])
            expected_writes.push_back(batch[i]);
    endfunction

    // Write check and receiver stalls
    always @(posedge aclk) begin : check_writes
        frame_write_t want;
        frame_write_t got;
        if (aresetn && m_tvalid && m_tready) begin
            got.address = m_tdata[AddrW-1:0];
            got.pixel   = m_tdata[AddrW +: PixW];
            got.last    = m_tlast;
            if (expected_writes.size() == 0) begin
                if (error_count < MAX_REPORTS)
                    $display("%0t: unexpected write addr=%0d pix=%0h last=%0b",
                             $realtime, got.address, got.pixel, got.last);
                error_count++;
            end else begin
                want = expected_writes.pop_front();
                if (got.address !== want.address || got.pixel !== want.pixel ||
                    got.last !== want.last) begin
                    if (error_count < MAX_REPORTS)
                        $display("%0t: write mismatch: expected addr=%0d pix=%0h last=%0b, %s",
                                 $realtime, want.address, want.pixel, want.last,
                                 $sformatf("got addr=%0d pix=%0h last=%0b",
                                           got.address, got.pixel, got.last));
                    error_count++;
                end
            end
        end
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Register write; cfg_valid stays high when another write follows
    task automatic write_register(input logic [CfgIdxW-1:0] index,
                                  input logic [CfgDataW-1:0] value,
                                  input bit lower_after);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        if (lower_after)
            cfg_valid <= 1'b0;
        case (index)
            REG_DEST_X:        window_cfg.dest_x        = value[8:0];
            REG_DEST_Y:        window_cfg.dest_y        = value[7:0];
            REG_REGION_WIDTH:  window_cfg.region_width  = value[9:0];
            REG_REGION_HEIGHT: window_cfg.region_height = value[9:0];
            REG_OFFSET_X:      window_cfg.offset_x      = value[9:0];
            REG_OFFSET_Y:      window_cfg.offset_y      = value[9:0];
            REG_KEY_ENABLE:    window_cfg.key_enable    = value[0];
            REG_KEY_COLOR:     window_cfg.key_color     = value[PixW-1:0];
            default: ;
        endcase
    endtask

    // Write all registers from reg_image, optionally hitting an unmapped index first
    task automatic apply_config(input bit poke_unmapped);
        if (poke_unmapped)
            write_register(CfgIdxW'($urandom_range(FIRST_UNMAPPED_REG, LAST_REG_INDEX)),
                           CfgDataW'($urandom_range(0, 1023)), 1'b0);
        for (int i = 0; i < NUM_REGS; i++)
            write_register(CfgIdxW'(i), reg_image[i], i == NUM_REGS - 1);
    endtask

    task automatic set_window(input int dx, input int dy, input int w, input int h,
                              input int ox, input int oy, input int key_en,
                              input int key_col);
        reg_image[REG_DEST_X]        = CfgDataW'(dx);
        reg_image[REG_DEST_Y]        = CfgDataW'(dy);
        reg_image[REG_REGION_WIDTH]  = CfgDataW'(w);
        reg_image[REG_REGION_HEIGHT] = CfgDataW'(h);
        reg_image[REG_OFFSET_X]      = CfgDataW'(ox);
        reg_image[REG_OFFSET_Y]      = CfgDataW'(oy);
        reg_image[REG_KEY_ENABLE]    = CfgDataW'(key_en);
        reg_image[REG_KEY_COLOR]     = CfgDataW'(key_col);
    endtask

    // One sheet word, with random idle cycles ahead of it
    task automatic send_word(input logic [WordW-1:0] word, input logic [ColW-1:0] col,
                             input logic [RowW-1:0] row);
        if ($urandom_range(99) < sender_idle_pct) begin
            s_tvalid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < sender_idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(STdataW - WordW - ColW - RowW){1'b0}}, row, col, word};
        do @(posedge aclk); while (!s_tready);
        predict_frame_writes(word, col, row);
    endtask

    // Drain: all writes in, then let zero-write words clear the pipeline
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (expected_writes.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // Reset window is empty: nothing comes out
    task automatic test_reset_window();
        send_word(32'h0000_0000, 7'd0, 10'd0);
        send_word(32'hffff_ffff, 7'd127, 10'd1023);
        wait_idle();
    endtask

    // Keying defaults, frame corner and off-frame words
    task automatic test_reset_keying();
        write_register(REG_REGION_WIDTH, 10'd1023, 1'b0);
        write_register(REG_REGION_HEIGHT, 10'd1023, 1'b1);
        send_word(32'hdddd_dddd, 7'd0, 10'd0);
        send_word(32'hfedc_ba98, 7'd0, 10'd0);
        send_word(32'h7654_3210, 7'd39, 10'd239);
        send_word(32'h7654_3210, 7'd127, 10'd1023);
        wait_idle();
    endtask

    // Right and bottom frame clipping, keying off and on
    task automatic test_clip_and_key();
        set_window(317, 239, 1023, 1023, 0, 0, 0, 0);
        apply_config(1'b0);
        send_word(32'h0000_0000, 7'd0, 10'd0);
        send_word(32'h1234_5678, 7'd0, 10'd1);
        wait_idle();
        set_window(317, 239, 1023, 1023, 0, 0, 1, 0);
        apply_config(1'b0);
        send_word(32'h0000_0000, 7'd0, 10'd0);
        send_word(32'h1020_3040, 7'd0, 10'd0);
        wait_idle();
        set_window(0, 0, 1023, 1023, 0, 0, 1, 15);
        apply_config(1'b0);
        send_word(32'hffff_ffff, 7'd0, 10'd0);
        send_word(32'hf0f0_f0f0, 7'd1, 10'd2);
        wait_idle();
    endtask

    // Partial words at the window edges, rows just outside, far sheet corner
    task automatic test_window_edges();
        set_window(0, 0, 10, 2, 5, 3, 1, 13);
        apply_config(1'b0);
        send_word(32'h89ab_cdef, 7'd0, 10'd3);
        send_word(32'h0123_4567, 7'd1, 10'd4);
        send_word(32'h0123_4567, 7'd1, 10'd2);
        send_word(32'h0123_4567, 7'd1, 10'd5);
        send_word(32'h0123_4567, 7'd2, 10'd3);
        wait_idle();
        set_window(0, 0, 1023, 1, 1023, 1023, 1, 13);
        apply_config(1'b0);
        send_word(32'h7000_0000, 7'd127, 10'd1023);
        send_word(32'h7000_0000, 7'd127, 10'd1022);
        wait_idle();
    endtask

    // Out-of-range register data is masked; unmapped indexes are ignored
    task automatic test_register_masking();
        set_window(10'h3ff, 0, 64, 64, 0, 0, 10'h3fe, 10'h3fd);
        apply_config(1'b1);
        send_word(32'h1234_5678, 7'd0, 10'd0);
        wait_idle();
        set_window(10'h205, 10'h3f0, 64, 64, 0, 0, 10'h3fe, 10'h3fd);
        apply_config(1'b1);
        send_word(32'h1234_5678, 7'd0, 10'd0);
        wait_idle();
        set_window(10'h205, 10'h10a, 64, 64, 0, 0, 10'h3fe, 10'h3fd);
        apply_config(1'b1);
        send_word(32'hdddd_0000, 7'd0, 10'd0);
        wait_idle();
    endtask

    // New random window; a few settings are the register extremes
    task automatic randomize_window();
        case ($urandom_range(9))
            0: set_window(0, 0, 1023, 1023, 0, 0, $urandom_range(0, 1023),
                          $urandom_range(0, 1023));
            1: set_window(319, 239, 1023, 1023, 1023, 1023, $urandom_range(0, 1023),
                          $urandom_range(0, 1023));
            default: begin
                reg_image[REG_DEST_X] = ($urandom_range(3) == 0) ?
                    CfgDataW'($urandom_range(0, 1023)) : CfgDataW'($urandom_range(0, 319));
                reg_image[REG_DEST_Y] = ($urandom_range(3) == 0) ?
                    CfgDataW'($urandom_range(0, 1023)) : CfgDataW'($urandom_range(0, 239));
                case ($urandom_range(19))
                    0: reg_image[REG_REGION_WIDTH] = '0;
                    1: reg_image[REG_REGION_WIDTH] = 10'd1023;
                    default: reg_image[REG_REGION_WIDTH] = CfgDataW'($urandom_range(1, 48));
                endcase
                case ($urandom_range(19))
                    0: reg_image[REG_REGION_HEIGHT] = '0;
                    1: reg_image[REG_REGION_HEIGHT] = 10'd1023;
                    default: reg_image[REG_REGION_HEIGHT] = CfgDataW'($urandom_range(1, 16));
                endcase
                reg_image[REG_OFFSET_X]   = CfgDataW'($urandom_range(0, 1023));
                reg_image[REG_OFFSET_Y]   = CfgDataW'($urandom_range(0, 1023));
                reg_image[REG_KEY_ENABLE] = CfgDataW'($urandom_range(0, 1023));
                reg_image[REG_KEY_COLOR]  = CfgDataW'($urandom_range(0, 1023));
            end
        endcase
    endtask

    // Mostly words inside the window with key-colored nibbles mixed in
    task automatic send_random_word();
        logic [WordW-1:0] word;
        int unsigned      r;
        int unsigned      c;
        logic [ColW-1:0]  col;
        logic [RowW-1:0]  row;
        word = $urandom;
        for (int k = 0; k < PixPerWord; k++)
            if ($urandom_range(3) == 0)
                word[4*k +: 4] = window_cfg.key_color;
        if ($urandom_range(99) < 82 && window_cfg.region_width != 0 &&
            window_cfg.region_height != 0) begin
            r = int'(window_cfg.offset_y) +
                $urandom_range(0, int'(window_cfg.region_height) - 1);
            c = int'(window_cfg.offset_x) +
                $urandom_range(0, int'(window_cfg.region_width) - 1);
            if (r > 1023) r = 1023;
            if (c > 1023) c = 1023;
            row = RowW'(r);
            col = ColW'(c / PixPerWord);
        end else begin
            row = RowW'($urandom_range(0, 1023));
            col = ColW'($urandom_range(0, 127));
        end
        send_word(word, col, row);
    endtask

    // Random traffic under one idle/stall mix, several window settings
    task automatic test_random_traffic(input int idle_pct, input int stall_pct,
                                       input int n_items);
        int sent;
        int batch;
        sender_idle_pct = idle_pct;
        recv_stall_pct  = stall_pct;
        sent = 0;
        while (sent < n_items) begin
            randomize_window();
            apply_config($urandom_range(3) == 0);
            batch = $urandom_range(20, 36);
            if (batch > n_items - sent)
                batch = n_items - sent;
            repeat (batch) send_random_word();
            sent += batch;
            wait_idle();
        end
    endtask

    initial begin
        window_cfg            = '0;
        window_cfg.key_enable = KEY_ENABLE_RST;
        window_cfg.key_color  = KEY_COLOR_RST;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        test_reset_window();
        test_reset_keying();
        test_clip_and_key();
        test_window_edges();
        test_register_masking();
        test_random_traffic(0, 0, 115);
        test_random_traffic(51, 0, 115);
        test_random_traffic(0, 51, 115);
        test_random_traffic(19, 19, 115);

        wait_idle();
        if (error_count == 0) begin
            $display("testbench: done, clean");
        end else begin
            $display("testbench: done, errors");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #LIMIT_NS;
        $display("testbench: done, errors");
        $finish;
    end

endmodule
